[hdl/assert_macros.svh]
// Assertion macros used by the top-level design file.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[hdl/prq_pkg.sv]
// Types and codes shared by the priority ready queue modules.
// Depends on nothing.
package prq_pkg;

  localparam int unsigned OP_W = 3;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned PRIO_IN_W = 8;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_POP    = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_EMPTY     = 2'd1,
    ERR_QUEUED    = 2'd2,
    ERR_NOT_QUEUED = 2'd3
  } err_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [SLOT_W-1:0]    entry;
    logic [PRIO_IN_W-1:0] priority_req;
  } in_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] result_entry;
    logic              result_valid;
    logic              now_empty;
    logic [1:0]        error_code;
  } out_res_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;     // capture request
    logic capture;  // latch the error code before the list changes
    logic clear;    // drop all flags, empty list
    logic walk_init;// cursor <= head
    logic walk_step;// cursor <= next[cursor]
    logic link;     // link entry ahead of cursor (cursor null: tail)
    logic unlink;   // unlink target (head for pop, entry for remove)
    logic respond;  // drive result strobe
  } prq_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bad;      // request ends in an error or a no-op
    logic            walk_done;
  } prq_sts_t;

endpackage

[hdl/priority_ready_queue_top.sv]
// Priority ready queue: one request in, one result strobe out, receiver cannot stall.
// A request passes decode and the response if it ends in an error or uses an unused code;
// clear, append, pop and remove pass decode, apply and the response, and insert by priority
// walks the next links between decode and apply, one link read per cycle, passing at most
// ENTRIES entries; the next request can be taken at the edge that takes the result.
// Synchronous active-low reset empties the queue; links and priorities are undefined.
`include "assert_macros.svh"
module priority_ready_queue_top #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  prq_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output prq_pkg::out_res_t out_res
);

  // Command and status between the controller and the datapath.
  prq_pkg::prq_cmd_t cmd;
  prq_pkg::prq_sts_t sts;

  // The controller sequences decode, the optional priority walk, the relink or clear and the response.
  prq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath holds the list and computes each result.
  prq_dp #(
    .ENTRIES       (ENTRIES),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_req),
    .cmd        (cmd),
    .sts        (sts),
    .res        (out_res),
    .res_strobe (out_strobe)
  );

  // A request that is accepted makes the block busy in the next cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept did not raise busy")
  // A result strobe lasts exactly one cycle.
  `ASSERT_NEXT(a_strobe_pulse, clk, rst_n, out_strobe, !out_strobe, "strobe held")
  // Link and unlink never occur together.
  `ASSERT_IMPL(a_cmd_excl, clk, rst_n, !(cmd.link && cmd.unlink), "link and unlink together")

endmodule

[hdl/prq_ctrl.sv]
// Controller state machine of the priority ready queue.
// Depends on prq_pkg.
module prq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  prq_pkg::prq_sts_t  sts,
  output prq_pkg::prq_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_WALK   = 5'b00100,
    S_APPLY  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.capture = 1'b1;
        if (sts.bad) begin
          state_nxt = S_DONE;
        end else if (sts.op == prq_pkg::OP_INSERT) begin
          cmd.walk_init = 1'b1;
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_APPLY;
        end
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_nxt = S_APPLY;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_APPLY: begin
        case (sts.op) inside
          prq_pkg::OP_CLEAR:  cmd.clear = 1'b1;
          prq_pkg::OP_APPEND, prq_pkg::OP_INSERT: cmd.link = 1'b1;
          default: cmd.unlink = 1'b1;
        endcase
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.respond = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[hdl/prq_dp.sv]
// Datapath of the priority ready queue: link stores, flags, head, tail, walk cursor.
// Depends on prq_pkg.
module prq_dp #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prq_pkg::in_req_t    req,
  input  prq_pkg::prq_cmd_t   cmd,
  output prq_pkg::prq_sts_t   sts,
  output prq_pkg::out_res_t   res,
  output logic                res_strobe
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = $clog2(ENTRIES + 2);
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);

  logic [LW-1:0]            next_link [ENTRIES];
  logic [LW-1:0]            prev_link [ENTRIES];
  logic [PRIORITY_BITS-1:0] prio_mem  [ENTRIES];
  logic [ENTRIES-1:0]       queued_r;
  logic [LW-1:0]            head_r, tail_r, cur_r, cur_nxt;
  logic [CW-1:0]            steps_r;

  logic [prq_pkg::OP_W-1:0]   op_r;
  logic [prq_pkg::SLOT_W-1:0] entry_r;
  logic [PRIORITY_BITS-1:0]   prio_r;
  logic [1:0]                 err_r;
  logic [prq_pkg::SLOT_W-1:0] res_entry_r;
  logic                       res_valid_r;

  logic          in_range;
  logic [IW-1:0] ent_i;
  logic [1:0]    err_c;

  assign in_range = ({{(32-prq_pkg::SLOT_W){1'b0}}, entry_r} < ENTRIES);
  assign ent_i = IW'(entry_r);

  always_comb begin
    err_c = prq_pkg::ERR_OK;
    case (op_r) inside
      prq_pkg::OP_APPEND, prq_pkg::OP_INSERT: begin
        if (!in_range) err_c = prq_pkg::ERR_NOT_QUEUED;
        else if (queued_r[ent_i]) err_c = prq_pkg::ERR_QUEUED;
      end
      prq_pkg::OP_POP: if (head_r == NIL) err_c = prq_pkg::ERR_EMPTY;
      prq_pkg::OP_REMOVE:
        if (!in_range || !queued_r[ent_i]) err_c = prq_pkg::ERR_NOT_QUEUED;
      default: err_c = prq_pkg::ERR_OK;
    endcase
  end

  assign sts.op = op_r;
  assign sts.bad = (err_c != prq_pkg::ERR_OK) || (op_r > prq_pkg::OP_REMOVE);
  assign sts.walk_done = (cur_r == NIL) || (steps_r >= CW'(ENTRIES)) ||
                         !(prio_mem[IW'(cur_r)] > prio_r);

  // Unlink target: head for pop, named entry for remove.
  logic [IW-1:0] tgt;
  logic [LW-1:0] un_n, un_p;
  logic [LW-1:0] lk_p;
  assign tgt  = (op_r == prq_pkg::OP_POP) ? IW'(head_r) : ent_i;
  assign un_n = next_link[tgt];
  assign un_p = prev_link[tgt];
  assign lk_p = (cur_r == NIL) ? tail_r : prev_link[IW'(cur_r)];

  always_comb begin
    cur_nxt = cur_r;
    if (cmd.walk_init) cur_nxt = head_r;
    else if (cmd.walk_step) cur_nxt = next_link[IW'(cur_r)];
    else if (cmd.load) cur_nxt = NIL;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= req.op;
      entry_r <= req.entry;
      prio_r  <= PRIORITY_BITS'(req.priority_req);
    end
    if (cmd.link) begin
      prio_mem[ent_i]  <= prio_r;
      prev_link[ent_i] <= lk_p;
      next_link[ent_i] <= cur_r;
      if (cur_r != NIL) prev_link[IW'(cur_r)] <= LW'(entry_r);
      if (lk_p != NIL) next_link[IW'(lk_p)] <= LW'(entry_r);
    end
    if (cmd.unlink) begin
      if (un_p != NIL) next_link[IW'(un_p)] <= un_n;
      if (un_n != NIL) prev_link[IW'(un_n)] <= un_p;
      next_link[tgt] <= NIL;
      prev_link[tgt] <= NIL;
    end
    if (cmd.load || cmd.walk_init) steps_r <= '0;
    else if (cmd.walk_step) steps_r <= steps_r + 1'b1;
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r <= '0;
      head_r <= NIL;
      tail_r <= NIL;
      res_strobe <= 1'b0;
      err_r <= '0;
      res_entry_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_strobe <= 1'b0;
      if (cmd.load) begin
        res_entry_r <= '0;
        res_valid_r <= 1'b0;
      end
      if (cmd.respond) res_strobe <= 1'b1;
      if (cmd.capture) err_r <= err_c;
      if (cmd.clear) begin
        queued_r <= '0;
        head_r <= NIL;
        tail_r <= NIL;
      end
      if (cmd.link) begin
        queued_r[ent_i] <= 1'b1;
        if (lk_p == NIL) head_r <= LW'(entry_r);
        if (cur_r == NIL) tail_r <= LW'(entry_r);
      end
      if (cmd.unlink) begin
        queued_r[tgt] <= 1'b0;
        if (un_p == NIL) head_r <= un_n;
        if (un_n == NIL) tail_r <= un_p;
        if (op_r == prq_pkg::OP_POP) begin
          res_entry_r <= prq_pkg::SLOT_W'(tgt);
          res_valid_r <= 1'b1;
        end else if (un_n != NIL) begin
          res_entry_r <= prq_pkg::SLOT_W'(un_n);
          res_valid_r <= 1'b1;
        end
      end
    end
  end

  assign res.result_entry = res_entry_r;
  assign res.result_valid = res_valid_r;
  assign res.now_empty    = (head_r == NIL);
  assign res.error_code   = err_r;

endmodule

[tb/tb.sv]
// Self-checking bench for the priority ready queue top level.
// Drives random and directed requests, predicts each result in a small scoreboard.
// Depends on prq_pkg and priority_ready_queue_top.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NSLOT = 16;
  localparam logic [4:0] NUL = 5'd16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // Scoreboard: holds its own copy of the linked list and the results still owed.
  class queue_scoreboard;
    logic [4:0] nxt [NSLOT];
    logic [4:0] prv [NSLOT];
    logic [7:0] prio [NSLOT];
    bit         queued [NSLOT];
    logic [4:0] head;
    logic [4:0] tail;
    prq_pkg::out_res_t owed [$];
    int         errors;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        nxt[i] = NUL; prv[i] = NUL; prio[i] = '0; queued[i] = 0;
      end
      head = NUL; tail = NUL; errors = 0;
    endfunction

    function logic [4:0] detach(logic [4:0] e);
      logic [4:0] n;
      logic [4:0] p;
      n = nxt[e];
      p = prv[e];
      if (p == NUL) head = n; else nxt[p] = n;
      if (n == NUL) tail = p; else prv[n] = p;
      nxt[e] = NUL; prv[e] = NUL; queued[e] = 0;
      return n;
    endfunction

    // Work out the result of one accepted request and note it.
    function void note_request(prq_pkg::in_req_t r);
      prq_pkg::out_res_t res;
      logic [4:0] at;
      logic [4:0] p;
      logic [4:0] n;
      int         steps;
      res = '0;
      case (r.op)
        prq_pkg::OP_CLEAR: begin
          for (int i = 0; i < NSLOT; i++) queued[i] = 0;
          head = NUL; tail = NUL;
        end
        prq_pkg::OP_APPEND, prq_pkg::OP_INSERT: begin
          if (queued[r.entry]) begin
            res.error_code = prq_pkg::ERR_QUEUED;
          end else begin
            prio[r.entry] = r.priority_req;
            at = NUL;
            if (r.op == prq_pkg::OP_INSERT) begin
              at = head;
              steps = 0;
              while (at != NUL && steps < NSLOT && prio[at] > r.priority_req) begin
                at = nxt[at];
                steps++;
              end
            end
            if (at == NUL) begin
              prv[r.entry] = tail; nxt[r.entry] = NUL;
              if (tail == NUL) head = r.entry; else nxt[tail] = r.entry;
              tail = r.entry;
            end else begin
              p = prv[at];
              prv[r.entry] = p; nxt[r.entry] = at; prv[at] = r.entry;
              if (p == NUL) head = r.entry; else nxt[p] = r.entry;
            end
            queued[r.entry] = 1;
          end
        end
        prq_pkg::OP_POP: begin
          if (head == NUL) begin
            res.error_code = prq_pkg::ERR_EMPTY;
          end else begin
            res.result_entry = head[3:0];
            res.result_valid = 1'b1;
            void'(detach(head));
          end
        end
        prq_pkg::OP_REMOVE: begin
          if (!queued[r.entry]) begin
            res.error_code = prq_pkg::ERR_NOT_QUEUED;
          end else begin
            n = detach(r.entry);
            if (n != NUL) begin
              res.result_entry = n[3:0];
              res.result_valid = 1'b1;
            end
          end
        end
        default: ;
      endcase
      res.now_empty = (head == NUL);
      owed.push_back(res);
    endfunction

    function void check_result(prq_pkg::out_res_t got);
      prq_pkg::out_res_t want;
      if (owed.size() == 0) begin
        $display("%0t: result with none owed, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.result_entry !== want.result_entry)
        begin $display("%0t: result_entry expected %0d actual %0d", $time,
                       want.result_entry, got.result_entry); errors++; end
      if (got.result_valid !== want.result_valid)
        begin $display("%0t: result_valid expected %0d actual %0d", $time,
                       want.result_valid, got.result_valid); errors++; end
      if (got.now_empty !== want.now_empty)
        begin $display("%0t: now_empty expected %0d actual %0d", $time,
                       want.now_empty, got.now_empty); errors++; end
      if (got.error_code !== want.error_code)
        begin $display("%0t: error_code expected %0d actual %0d", $time,
                       want.error_code, got.error_code); errors++; end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  prq_pkg::in_req_t  in_req;
  logic     out_strobe;
  prq_pkg::out_res_t out_res;

  queue_scoreboard sb;
  int idle_cycles;

  priority_ready_queue_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_strobe(out_strobe), .out_res(out_res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Results are checked at the edge that ends their strobe cycle. The watchdog
  // counts cycles in which neither a request nor a result is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_res);
      if (out_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("priority_ready_queue_top: mismatch");
        $finish;
      end
    end
  end

  // Offer one request and hold it until the block takes it. The offer starts one
  // edge after the call, so start is never driven twice in one time step.
  task automatic send_request(logic [2:0] op, logic [3:0] slot, logic [7:0] pr);
    prq_pkg::in_req_t r;
    r.op = op; r.entry = slot; r.priority_req = pr;
    @(posedge clk);
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    start <= 1'b0;
  endtask

  // Mostly short gaps, now and then a long one, often none at all.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) n = 0;
    else if (n < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    repeat (n) @(posedge clk);
  endtask

  // Random request: pushes and inserts dominate so the list grows long and
  // walks go deep; pops and removes drain it; clear and unused codes are rare.
  task automatic random_request();
    int pick;
    logic [2:0] op;
    logic [7:0] pr;
    pick = $urandom_range(0, 99);
    if (pick < 2) op = prq_pkg::OP_CLEAR;
    else if (pick < 22) op = prq_pkg::OP_APPEND;
    else if (pick < 52) op = prq_pkg::OP_INSERT;
    else if (pick < 72) op = prq_pkg::OP_POP;
    else if (pick < 97) op = prq_pkg::OP_REMOVE;
    else op = 3'($urandom_range(5, 7));
    // A narrow priority range forces many ties; sometimes the full range.
    pr = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3) * 85) : 8'($urandom);
    send_request(op, 4'($urandom), pr);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: errors on an empty queue, extremes of slot and priority,
    // ties ahead of equal priorities, removal of head and tail.
    send_request(prq_pkg::OP_POP, 4'd0, 8'd0);
    send_request(prq_pkg::OP_REMOVE, 4'd15, 8'd0);
    send_request(prq_pkg::OP_APPEND, 4'd0, 8'd0);
    send_request(prq_pkg::OP_APPEND, 4'd0, 8'd255);
    send_request(prq_pkg::OP_INSERT, 4'd0, 8'd255);
    send_request(prq_pkg::OP_INSERT, 4'd15, 8'd255);
    send_request(prq_pkg::OP_INSERT, 4'd7, 8'd255);
    send_request(prq_pkg::OP_INSERT, 4'd8, 8'd0);
    send_request(prq_pkg::OP_APPEND, 4'd9, 8'd128);
    send_request(prq_pkg::OP_INSERT, 4'd10, 8'd128);
    send_request(prq_pkg::OP_REMOVE, 4'd9, 8'd0);
    send_request(prq_pkg::OP_REMOVE, 4'd7, 8'd0);
    send_request(prq_pkg::OP_REMOVE, 4'd15, 8'd0);
    send_request(3'd5, 4'd3, 8'd1);
    send_request(3'd7, 4'd15, 8'd255);
    send_request(prq_pkg::OP_POP, 4'd0, 8'd0);
    send_request(prq_pkg::OP_POP, 4'd0, 8'd0);
    send_request(prq_pkg::OP_CLEAR, 4'd0, 8'd0);
    send_request(prq_pkg::OP_REMOVE, 4'd10, 8'd0);
    send_request(prq_pkg::OP_POP, 4'd0, 8'd0);
    // Fill every slot; each insert has a higher priority than all before it and goes in at the head.
    for (int i = 0; i < NSLOT; i++) send_request(prq_pkg::OP_INSERT, 4'(i), 8'(i * 16));

    for (int k = 0; k < 1800; k++) begin
      if ($urandom_range(0, 3) != 0) idle_gap();
      random_request();
    end

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (2 * NSLOT + 8) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("priority_ready_queue_top: match");
    end else begin
      $display("priority_ready_queue_top: mismatch");
    end
    $finish;
  end
endmodule
